// ===== rtl/assert_macros.svh =====
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deframer assertion failed");
// Check a property on every clock edge, reset included.
`define ASSERT_PROP_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deframer assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_PROP_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/rsd_pkg.sv =====
// Types and constants of the record segment deframer.
package rsd_pkg;

  localparam int unsigned FIRST_PAYLOAD = 10;
  localparam int unsigned LATER_PAYLOAD = 14;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_ID  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIRE_VERSION = 2'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_VERSION    = 3'd1,
    ST_ID         = 3'd2,
    ST_ORDINAL    = 3'd3,
    ST_SEG_COUNT  = 3'd4,
    ST_BYTE_COUNT = 3'd5,
    ST_PADDING    = 3'd6
  } status_t;

  // One segment as taken from the input channel
  typedef struct packed {
    logic        seg_last;
    logic [63:0] seg_high;
    logic [63:0] seg_low;
  } item_t;

  // Per-segment result control fields
  typedef struct packed {
    logic [3:0] payload_count;
    status_t    status;
    logic       record_end;
  } res_t;

endpackage

// ===== rtl/rsd_in_reg.sv =====
// Input register stage of the record segment deframer.
module rsd_in_reg
  import rsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  input  logic         advance,
  output item_t        item,
  output logic         item_valid
);

  item_t item_r;
  logic  valid_r;

  // take a new request whenever the held one is empty or moving on
  assign in_tready  = !valid_r || advance;
  assign item       = item_r;
  assign item_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // hold payload until it is consumed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.seg_low  <= in_tdata[63:0];
      item_r.seg_high <= in_tdata[127:64];
      item_r.seg_last <= in_tlast;
    end
  end

endmodule

// ===== rtl/rsd_check.sv =====
// Record state and per-segment checks of the record segment deframer.
module rsd_check
  import rsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  item_t       item,
  input  logic [7:0]  expected_id,
  input  logic [7:0]  wire_version,
  output logic [63:0] payload_low,
  output logic [47:0] payload_high,
  output res_t        res
);

  logic [7:0]  next_ordinal_r, next_ordinal_nxt;
  logic [7:0]  count_field_r, count_field_nxt;
  logic [15:0] total_bytes_r, total_bytes_nxt;
  logic [15:0] bytes_taken_r, bytes_taken_nxt;
  status_t     error_code_r, error_code_nxt;
  logic        in_record_r, in_record_nxt;
  logic        ordinal_over_r, ordinal_over_nxt;

  logic        first;
  logic [7:0]  b0, b1, b2, b3;
  logic [7:0]  cnt_cur;
  logic [15:0] tot_cur;
  logic [15:0] remain;
  logic [3:0]  cap;
  logic [3:0]  n;
  logic [111:0] slots;
  logic        pad_err;
  logic [15:0] rest;
  logic [16:0] rest_plus;
  logic [11:0] ord_x14;
  logic [8:0]  segs;
  logic        chk_version, chk_short, chk_id, chk_ord;
  logic        chk_segcnt, chk_need;
  status_t     err;

  assign first = !in_record_r;
  assign b0    = item.seg_low[7:0];
  assign b1    = item.seg_low[15:8];
  assign b2    = item.seg_low[23:16];
  assign b3    = item.seg_low[31:24];

  // header fields come from this segment when it opens a record
  assign cnt_cur = first ? b3 : count_field_r;
  assign tot_cur = first ? item.seg_low[47:32] : total_bytes_r;

  // pick the payload slots out of the segment
  always_comb begin
    if (first) begin
      payload_low  = {item.seg_high[47:0], item.seg_low[63:48]};
      payload_high = {32'd0, item.seg_high[63:48]};
      cap          = 4'(FIRST_PAYLOAD);
    end else begin
      payload_low  = {item.seg_high[15:0], item.seg_low[63:16]};
      payload_high = item.seg_high[63:16];
      cap          = 4'(LATER_PAYLOAD);
    end
  end
  assign slots = {payload_high, payload_low};

  // count record bytes in this segment; taken never exceeds total
  assign remain = tot_cur - bytes_taken_r;
  assign n      = (remain >= 16'(cap)) ? cap : remain[3:0];

  // slots past the record data must be zero
  always_comb begin
    pad_err = 1'b0;
    for (int s = 0; s < LATER_PAYLOAD; s++) begin
      if ((4'(s) >= n) && (slots[8*s +: 8] != 8'd0)) begin
        pad_err = 1'b1;
      end
    end
  end

  // segment count implied by the length: ceil(rest / 14) == ordinal
  assign rest      = tot_cur - 16'(FIRST_PAYLOAD);
  assign rest_plus = {1'b0, rest} + 17'(LATER_PAYLOAD);
  assign ord_x14   = 12'(next_ordinal_r) * 12'(LATER_PAYLOAD);
  assign segs      = {1'b0, next_ordinal_r} + 9'd1;

  assign chk_version = first && (b2 != wire_version);
  assign chk_short   = first && (tot_cur < 16'(FIRST_PAYLOAD));
  assign chk_id      = (b0 != expected_id);
  assign chk_ord     = ordinal_over_r || (b1 != next_ordinal_r);
  assign chk_segcnt  = item.seg_last && !ordinal_over_r && ({1'b0, cnt_cur} != segs);
  assign chk_need    = item.seg_last && !ordinal_over_r && !chk_short &&
                       !((rest <= 16'(ord_x14)) && (rest_plus > 17'(ord_x14)));

  // keep the first error in stream order
  always_comb begin
    if (error_code_r != ST_OK) err = error_code_r;
    else if (chk_version)      err = ST_VERSION;
    else if (chk_short)        err = ST_BYTE_COUNT;
    else if (chk_id)           err = ST_ID;
    else if (chk_ord)          err = ST_ORDINAL;
    else if (pad_err)          err = ST_PADDING;
    else if (chk_segcnt)       err = ST_SEG_COUNT;
    else if (chk_need)         err = ST_BYTE_COUNT;
    else                       err = ST_OK;
  end

  assign res.payload_count = (err != ST_OK) ? 4'd0 : n;
  assign res.status        = err;
  assign res.record_end    = item.seg_last;

  // advance record state; rearm after the last segment
  always_comb begin
    count_field_nxt  = cnt_cur;
    total_bytes_nxt  = tot_cur;
    if (item.seg_last) begin
      next_ordinal_nxt = 8'd0;
      bytes_taken_nxt  = 16'd0;
      error_code_nxt   = ST_OK;
      in_record_nxt    = 1'b0;
      ordinal_over_nxt = 1'b0;
    end else begin
      next_ordinal_nxt = next_ordinal_r + 8'd1;
      bytes_taken_nxt  = bytes_taken_r + 16'(n);
      error_code_nxt   = err;
      in_record_nxt    = 1'b1;
      ordinal_over_nxt = ordinal_over_r || (next_ordinal_r == 8'hFF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ordinal_r <= 8'd0;
      count_field_r  <= 8'd0;
      total_bytes_r  <= 16'd0;
      bytes_taken_r  <= 16'd0;
      error_code_r   <= ST_OK;
      in_record_r    <= 1'b0;
      ordinal_over_r <= 1'b0;
    end else if (take) begin
      next_ordinal_r <= next_ordinal_nxt;
      count_field_r  <= count_field_nxt;
      total_bytes_r  <= total_bytes_nxt;
      bytes_taken_r  <= bytes_taken_nxt;
      error_code_r   <= error_code_nxt;
      in_record_r    <= in_record_nxt;
      ordinal_over_r <= ordinal_over_nxt;
    end
  end

endmodule

// ===== rtl/record_segment_deframer.sv =====
// Top level of the record segment deframer.
// Usage:
//   Segments of a record enter on the in_ channel, one 128-bit segment per
//   request, in_tlast set on the final one. Each segment yields one result on
//   the out_ channel: its payload slots, how many of them are record data,
//   the latched status, and out_tlast echoing the segment's end marker.
//   Registers expected_id (index 0) and wire_version (index 1) are written
//   through cfg_we / cfg_addr / cfg_wdata; the user writes them only while
//   no record is in flight, and the block itself does not enforce this.
// Timing:
//   A segment is held in an input register, checked by one level of logic
//   against the record state and lands in the output register, which drives
//   out_tvalid. One segment per cycle is sustained while out_tready is high;
//   the record state update is the loop that sets this rate.
// Reset (rst_n low, synchronous) empties both registers, clears the record
// state and loads both config registers with 1.
// When the receiver stalls the output holds, the input register still fills
// once, then in_tready drops until the result is taken.
module record_segment_deframer
  import rsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [127:0]          in_tdata,   // seg_low[63:0], seg_high[127:64]
  input  logic                  in_tlast,   // seg_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // payload_low[63:0], payload_high[111:64], payload_count[115:112],
  // status[118:116], zero[119]
  output logic [119:0]          out_tdata,
  output logic                  out_tlast,  // record_end
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  logic [7:0]  expected_id_r;
  logic [7:0]  wire_version_r;
  item_t       item;
  logic        item_valid;
  logic        advance;
  logic [63:0] payload_low;
  logic [47:0] payload_high;
  res_t        res;

  logic        out_valid_r;
  logic [63:0] payload_low_r;
  logic [47:0] payload_high_r;
  res_t        res_r;

  // write config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r  <= 8'd1;
      wire_version_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_EXPECTED_ID:  expected_id_r  <= cfg_wdata;
        CFG_WIRE_VERSION: wire_version_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // move a segment on whenever the output register is free or draining
  assign advance = item_valid && (!out_valid_r || out_tready);

  rsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  rsd_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (advance),
    .item         (item),
    .expected_id  (expected_id_r),
    .wire_version (wire_version_r),
    .payload_low  (payload_low),
    .payload_high (payload_high),
    .res          (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      payload_low_r  <= payload_low;
      payload_high_r <= payload_high;
      res_r          <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.status, res_r.payload_count, payload_high_r, payload_low_r};
  assign out_tlast  = res_r.record_end;

  // an errored result never claims record data
  `ASSERT_PROP(a_no_count_on_error, clk, rst_n, out_tvalid && (res_r.status != ST_OK) |-> res_r.payload_count == 4'd0)
  // a result only appears after a segment moved out of the input register
  `ASSERT_PROP(a_valid_from_advance, clk, rst_n, $rose(out_tvalid) |-> $past(advance))
  // moving a segment on always frees the input side
  `ASSERT_PROP(a_advance_ready, clk, rst_n, advance |-> in_tready)
  // reset leaves no result pending
  `ASSERT_PROP_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_tvalid)

endmodule

// ===== tb/sv/record_segment_deframer_test.sv =====
// Self-checking stream testbench for the record segment deframer.
module record_segment_deframer_test
  import rsd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_SEGMENTS = 220;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_HI = 2'd3;

  // Ways a generated record departs from a well-formed one
  typedef enum int {
    FAULT_NONE,
    FAULT_VERSION,
    FAULT_ID,
    FAULT_ORDINAL,
    FAULT_PADDING,
    FAULT_OPEN_END,
    FAULT_SEG_COUNT,
    FAULT_LENGTH,
    FAULT_SHORT
  } fault_t;

  // Expected contents of one result request
  typedef struct packed {
    logic [63:0] payload_low;
    logic [47:0] payload_high;
    logic [3:0]  payload_count;
    status_t     status;
    logic        record_end;
  } seg_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of registers and record state
  logic [7:0]  want_id = 8'd1;
  logic [7:0]  want_version = 8'd1;
  logic [7:0]  next_ordinal = '0;
  logic [7:0]  count_field = '0;
  logic [15:0] total_bytes = '0;
  logic [15:0] bytes_taken = '0;
  status_t     latched_status = ST_OK;
  logic        rec_open = 1'b0;
  logic        ordinal_wrapped = 1'b0;

  item_t       segment_queue[$];
  seg_result_t owed_results[$];
  int unsigned segments_queued = 0;
  int unsigned results_seen = 0;
  logic        tail_open = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  record_segment_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Keep the earliest fault of the record
  function automatic status_t first_fault(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  // Check one segment against the record state and advance it
  function automatic seg_result_t deframe_segment(logic [127:0] seg, logic last);
    seg_result_t r;
    status_t err;
    logic first;
    logic [7:0] v;
    int unsigned src, cap, n, segs, need;
    r = '0;
    first = !rec_open;
    err = latched_status;
    n = 0;
    if (first) begin
      next_ordinal = '0;
      ordinal_wrapped = 1'b0;
      bytes_taken = '0;
      count_field = seg[31:24];
      total_bytes = seg[47:32];
      if (seg[23:16] != want_version) err = first_fault(err, ST_VERSION);
      if (total_bytes < FIRST_PAYLOAD) err = first_fault(err, ST_BYTE_COUNT);
    end
    if (seg[7:0] != want_id) err = first_fault(err, ST_ID);
    if (ordinal_wrapped || seg[15:8] != next_ordinal) err = first_fault(err, ST_ORDINAL);
    src = first ? 6 : 2;
    cap = first ? FIRST_PAYLOAD : LATER_PAYLOAD;
    for (int unsigned s = 0; s < cap; s++) begin
      v = seg[8*(src+s) +: 8];
      if (s < 8) r.payload_low[8*s +: 8] = v;
      else r.payload_high[8*(s-8) +: 8] = v;
      if (bytes_taken < total_bytes) begin
        bytes_taken = bytes_taken + 16'd1;
        n++;
      end else if (v != 8'd0) begin
        err = first_fault(err, ST_PADDING);
      end
    end
    // Count checks only make sense while ordinals still fit in a byte
    if (last && !ordinal_wrapped) begin
      segs = next_ordinal + 1;
      if (count_field != segs) err = first_fault(err, ST_SEG_COUNT);
      if (total_bytes >= FIRST_PAYLOAD) begin
        need = 1 + (total_bytes - FIRST_PAYLOAD + LATER_PAYLOAD - 1) / LATER_PAYLOAD;
        if (need != segs) err = first_fault(err, ST_BYTE_COUNT);
      end
    end
    if (next_ordinal == 8'hFF) ordinal_wrapped = 1'b1;
    next_ordinal = next_ordinal + 8'd1;
    latched_status = err;
    r.payload_count = (err != ST_OK) ? 4'd0 : 4'(n);
    r.status = err;
    r.record_end = last;
    // Rearm for the next record
    if (last) begin
      next_ordinal = '0;
      bytes_taken = '0;
      latched_status = ST_OK;
      rec_open = 1'b0;
      ordinal_wrapped = 1'b0;
    end else begin
      rec_open = 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned draw_wait(bit quiet);
    if (quiet) return 0;
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return $urandom_range(0, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic push_segment(input logic [127:0] seg, input logic last);
    item_t it;
    it.seg_low = seg[63:0];
    it.seg_high = seg[127:64];
    it.seg_last = last;
    segment_queue = {segment_queue, it};
    segments_queued++;
    tail_open = !last;
  endtask

  // Build a record of segs segments; fill < 0 gives random payload bytes
  task automatic queue_record(input int unsigned segs, input int unsigned len,
                              input int unsigned cnt, input fault_t fault, input int fill);
    int unsigned bytes_left, bad_seg, src;
    logic [127:0] seg;
    logic [7:0] v;
    logic tail_pad;
    bytes_left = len;
    bad_seg = $urandom_range(0, segs - 1);
    for (int unsigned i = 0; i < segs; i++) begin
      seg = '0;
      tail_pad = 1'b0;
      seg[7:0] = want_id;
      if (fault == FAULT_ID && i == bad_seg) seg[7:0] ^= 8'($urandom_range(1, 255));
      seg[15:8] = 8'(i);
      if (fault == FAULT_ORDINAL && i == bad_seg) seg[15:8] += 8'($urandom_range(1, 255));
      if (i == 0) begin
        seg[23:16] = want_version;
        if (fault == FAULT_VERSION) seg[23:16] ^= 8'($urandom_range(1, 255));
        seg[31:24] = 8'(cnt);
        seg[47:32] = 16'(len);
        src = 6;
      end else begin
        src = 2;
      end
      for (int unsigned k = src; k < 16; k++) begin
        if (bytes_left > 0) begin
          v = (fill < 0) ? 8'($urandom) : 8'(fill);
          bytes_left--;
          tail_pad = 1'b0;
        end else begin
          v = 8'd0;
          tail_pad = 1'b1;
        end
        seg[8*k +: 8] = v;
      end
      if (fault == FAULT_PADDING && i == segs - 1 && tail_pad)
        seg[127:120] = 8'($urandom_range(1, 255));
      push_segment(seg, (i == segs - 1) && (fault != FAULT_OPEN_END));
    end
  endtask

  // Byte length whose implied segment count matches segs
  function automatic int unsigned length_for(int unsigned segs);
    if (segs == 1) return FIRST_PAYLOAD;
    return $urandom_range(FIRST_PAYLOAD + LATER_PAYLOAD * (segs - 2) + 1,
                          FIRST_PAYLOAD + LATER_PAYLOAD * (segs - 1));
  endfunction

  // Mostly well-formed records with random content, some broken, some noise
  task automatic queue_random_phase(input int unsigned target);
    int unsigned stop, segs, len, cnt;
    fault_t fault;
    stop = segments_queued + target;
    while (segments_queued < stop) begin
      if ($urandom_range(0, 99) < 5) begin
        push_segment({$urandom, $urandom, $urandom, $urandom}, 1'($urandom));
      end else begin
        segs = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        len = length_for(segs);
        cnt = segs;
        fault = FAULT_NONE;
        if ($urandom_range(0, 99) < 30) fault = fault_t'($urandom_range(FAULT_VERSION, FAULT_SHORT));
        case (fault)
          FAULT_SEG_COUNT: cnt = $urandom_range(0, 255);
          FAULT_LENGTH: len = $urandom_range(0, 65535);
          FAULT_SHORT: len = $urandom_range(0, FIRST_PAYLOAD - 1);
          default: ;
        endcase
        queue_record(segs, len, cnt, fault, -1);
      end
    end
    // Close any record left open so the phase ends on a boundary
    if (tail_open) push_segment({$urandom, $urandom, $urandom, $urandom}, 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    if (addr == CFG_EXPECTED_ID) want_id = data;
    else if (addr == CFG_WIRE_VERSION) want_version = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued segment has come back as a result
  task automatic wait_idle();
    while (results_seen < segments_queued)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drive segment requests and predict each accepted one
  always @(posedge clk) begin : drive_in
    int unsigned gap;
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      gap = in_gap;
      if (in_tvalid && in_tready) begin
        owed_results = {owed_results, deframe_segment(in_tdata, in_tlast)};
        gap = draw_wait(in_quiet);
      end
      if (in_tvalid && !in_tready) begin
        // hold the request until taken
      end else if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap <= gap - 1;
      end else if (segment_queue.size() != 0) begin
        nxt = segment_queue.pop_front();
        in_tdata <= {nxt.seg_high, nxt.seg_low};
        in_tlast <= nxt.seg_last;
        in_tvalid <= 1'b1;
        in_gap <= 0;
      end else begin
        in_tvalid <= 1'b0;
        in_gap <= 0;
      end
    end
  end

  // Take result requests with random stalls and compare field by field
  always @(posedge clk) begin : watch_out
    int unsigned gap;
    seg_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      gap = out_gap;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          report_mismatch("result with no segment owed", out_tdata[63:0], '0);
        end else begin
          want = owed_results.pop_front();
          if (out_tdata[63:0] !== want.payload_low)
            report_mismatch("payload_low", out_tdata[63:0], want.payload_low);
          if (out_tdata[111:64] !== want.payload_high)
            report_mismatch("payload_high", out_tdata[111:64], want.payload_high);
          if (out_tdata[115:112] !== want.payload_count)
            report_mismatch("payload_count", out_tdata[115:112], want.payload_count);
          if (out_tdata[118:116] !== want.status)
            report_mismatch("status", out_tdata[118:116], want.status);
          if (out_tdata[119] !== 1'b0)
            report_mismatch("spare bit", out_tdata[119], 1'b0);
          if (out_tlast !== want.record_end)
            report_mismatch("record_end", out_tlast, want.record_end);
        end
        gap = draw_wait(out_quiet);
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        out_gap <= gap - 1;
      end else begin
        out_tready <= 1'b1;
        out_gap <= 0;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed records at reset register values
    queue_record(1, 10, 1, FAULT_NONE, 'hFF);      // one segment, all-ones payload
    queue_record(2, 24, 2, FAULT_NONE, 'h00);      // full second segment, zero data
    queue_record(1, 10, 1, FAULT_VERSION, -1);
    queue_record(1, 9, 1, FAULT_NONE, -1);         // length below the first payload
    queue_record(1, 0, 1, FAULT_PADDING, -1);      // zero length beats padding fault
    queue_record(2, 20, 2, FAULT_ID, -1);
    queue_record(3, 30, 3, FAULT_ORDINAL, -1);
    queue_record(2, 20, 3, FAULT_NONE, -1);        // count field off by one
    queue_record(2, 30, 2, FAULT_NONE, -1);        // length implies three segments
    queue_record(2, 11, 2, FAULT_PADDING, -1);
    queue_record(1, 65535, 1, FAULT_NONE, 'hFF);   // maximum length
    queue_record(2, 20, 2, FAULT_OPEN_END, -1);    // this record runs on into the next one
    queue_record(1, 10, 1, FAULT_NONE, -1);
    queue_record(1, 10, 0, FAULT_NONE, -1);
    queue_record(1, 10, 255, FAULT_NONE, -1);
    wait_idle();

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_EXPECTED_ID, 8'd255);
          write_reg(CFG_WIRE_VERSION, 8'd0);
        end
        1: begin
          write_reg(CFG_WIRE_VERSION, 8'd255);
        end
        2: begin
          write_reg(CFG_EXPECTED_ID, 8'd1);
          write_reg(CFG_WIRE_VERSION, 8'd0);
        end
        default: begin
          write_reg(CFG_EXPECTED_ID, 8'($urandom_range(1, 255)));
          write_reg(CFG_WIRE_VERSION, 8'($urandom_range(0, 255)));
          write_reg((p % 2 != 0) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO, 8'($urandom));
        end
      endcase
      in_quiet = (p == 2);
      out_quiet = (p == 2 || p == 4);
      if (p == 3) begin
        // Records at and past the ordinal range
        queue_record(256, FIRST_PAYLOAD + LATER_PAYLOAD * 254, 0, FAULT_NONE, -1);
        queue_record(258, FIRST_PAYLOAD + LATER_PAYLOAD * 256, 2, FAULT_NONE, -1);
      end
      queue_random_phase(PHASE_SEGMENTS);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
